// ===== rtl/vlps_pkg.sv =====
// Shared types and constants for the vector line point stroker.
// Used by the controller, the datapath and the top level. No dependencies.
package vlps_pkg;

  localparam int COORD_W  = 16;
  localparam int STEP_W   = 6;
  localparam int CNT_W    = 4;
  localparam int DIV_LAST = 15;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [STEP_W-1:0]  step_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new segment and start the span division
    logic div_step;  // one restoring-division step on both lanes
    logic div_axis;  // lanes divide the axis spans by the step count
    logic setup;     // settle the step count and load the axis spans
    logic prep;      // take per-step increments and clear accumulators
    logic emit;      // load the next point into the output register
  } vlps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;      // the next point emitted is the segment end
  } vlps_sts_t;

endpackage

// ===== rtl/vlps_ctrl.sv =====
// Controller state machine of the vector line point stroker.
// Depends on vlps_pkg; drives the datapath through vlps_cmd_t.
module vlps_ctrl import vlps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  vlps_sts_t sts,
  output vlps_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIVS  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_DIVA  = 3'd3;
  localparam logic [2:0] S_PREP  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  cnt_t       cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIVS;
        end
      end
      S_DIVS: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_LAST)) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIVA;
      end
      S_DIVA: begin
        cmd.div_step = 1'b1;
        cmd.div_axis = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_LAST)) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/vlps_dp.sv =====
// Datapath of the vector line point stroker: two restoring-division lanes,
// incremental quotient/remainder point generators and the output register.
// Depends on vlps_pkg; steered by vlps_ctrl through vlps_cmd_t.
module vlps_dp import vlps_pkg::*; #(
  parameter int MAX_STEPS = 63
) (
  input  logic      clk,
  input  logic [79:0] in_tdata,
  input  vlps_cmd_t cmd,
  output vlps_sts_t sts,
  output logic [31:0] out_tdata,
  output logic      out_tlast,
  output logic      out_tuser
);

  coord_t xs_r, ys_r, ax_r, ay_r, spacing_r;
  logic   xneg_r, yneg_r;
  coord_t quo_x_r, rem_x_r, quo_y_r, rem_y_r;
  step_t  steps_r, idx_r;
  logic   capped_r;
  coord_t inc_x_r, inc_y_r, accq_x_r, accq_y_r;
  step_t  frac_x_r, frac_y_r, accr_x_r, accr_y_r;
  coord_t pt_x_r, pt_y_r;
  logic   last_r, cap_out_r;

  coord_t in_xs, in_ys, in_xe, in_ye;
  coord_t div_x;
  logic [COORD_W:0] sh_x, sh_y, dv_x, dv_y;
  logic   ge_x, ge_y;
  logic [STEP_W:0] sum_x, sum_y;
  logic   wrap_x, wrap_y;

  assign in_xs = in_tdata[15:0];
  assign in_ys = in_tdata[31:16];
  assign in_xe = in_tdata[47:32];
  assign in_ye = in_tdata[63:48];

  // Lane X divides the span by the spacing first, then |dx| by the step count.
  assign div_x = cmd.div_axis ? coord_t'(steps_r) : spacing_r;
  assign sh_x  = {rem_x_r, quo_x_r[COORD_W-1]};
  assign sh_y  = {rem_y_r, quo_y_r[COORD_W-1]};
  assign dv_x  = {1'b0, div_x};
  assign dv_y  = {1'b0, coord_t'(steps_r)};
  assign ge_x  = (sh_x >= dv_x);
  assign ge_y  = (sh_y >= dv_y);

  assign sum_x  = {1'b0, accr_x_r} + {1'b0, frac_x_r};
  assign sum_y  = {1'b0, accr_y_r} + {1'b0, frac_y_r};
  assign wrap_x = (sum_x >= {1'b0, steps_r});
  assign wrap_y = (sum_y >= {1'b0, steps_r});

  assign sts.last = (idx_r == steps_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xs_r      <= in_xs;
      ys_r      <= in_ys;
      xneg_r    <= (in_xe < in_xs);
      yneg_r    <= (in_ye < in_ys);
      ax_r      <= (in_xe < in_xs) ? in_xs - in_xe : in_xe - in_xs;
      ay_r      <= (in_ye < in_ys) ? in_ys - in_ye : in_ye - in_ys;
      spacing_r <= in_tdata[79:64];
    end
    if (cmd.load) begin
      // The larger span goes into lane X; the remainder starts at zero.
      quo_x_r <= ((in_xe < in_xs) ? in_xs - in_xe : in_xe - in_xs) >
                 ((in_ye < in_ys) ? in_ys - in_ye : in_ye - in_ys) ?
                 ((in_xe < in_xs) ? in_xs - in_xe : in_xe - in_xs) :
                 ((in_ye < in_ys) ? in_ys - in_ye : in_ye - in_ys);
      rem_x_r <= '0;
    end else if (cmd.setup) begin
      quo_x_r <= ax_r;
      rem_x_r <= '0;
      quo_y_r <= ay_r;
      rem_y_r <= '0;
    end else if (cmd.div_step) begin
      quo_x_r <= {quo_x_r[COORD_W-2:0], ge_x};
      rem_x_r <= ge_x ? coord_t'(sh_x - dv_x) : coord_t'(sh_x);
      quo_y_r <= {quo_y_r[COORD_W-2:0], ge_y};
      rem_y_r <= ge_y ? coord_t'(sh_y - dv_y) : coord_t'(sh_y);
    end
    if (cmd.setup) begin
      // A zero spacing divides to all ones and so lands in the cap.
      if (quo_x_r > coord_t'(MAX_STEPS)) begin
        steps_r  <= STEP_W'(MAX_STEPS);
        capped_r <= 1'b1;
      end else if (quo_x_r == '0) begin
        steps_r  <= STEP_W'(1);
        capped_r <= 1'b0;
      end else begin
        steps_r  <= quo_x_r[STEP_W-1:0];
        capped_r <= 1'b0;
      end
    end
    if (cmd.prep) begin
      inc_x_r  <= quo_x_r;
      inc_y_r  <= quo_y_r;
      frac_x_r <= rem_x_r[STEP_W-1:0];
      frac_y_r <= rem_y_r[STEP_W-1:0];
      accq_x_r <= '0;
      accq_y_r <= '0;
      accr_x_r <= '0;
      accr_y_r <= '0;
      idx_r    <= '0;
    end else if (cmd.emit) begin
      idx_r    <= idx_r + 1'b1;
      accq_x_r <= accq_x_r + inc_x_r + coord_t'(wrap_x);
      accq_y_r <= accq_y_r + inc_y_r + coord_t'(wrap_y);
      accr_x_r <= wrap_x ? step_t'(sum_x - {1'b0, steps_r}) : sum_x[STEP_W-1:0];
      accr_y_r <= wrap_y ? step_t'(sum_y - {1'b0, steps_r}) : sum_y[STEP_W-1:0];
    end
    if (cmd.emit) begin
      pt_x_r    <= xneg_r ? xs_r - accq_x_r : xs_r + accq_x_r;
      pt_y_r    <= yneg_r ? ys_r - accq_y_r : ys_r + accq_y_r;
      last_r    <= (idx_r == steps_r);
      cap_out_r <= capped_r;
    end
  end

  assign out_tdata = {pt_y_r, pt_x_r};
  assign out_tlast = last_r;
  assign out_tuser = cap_out_r;

endmodule

// ===== rtl/vector_line_point_stroker.sv =====
// Sequence: after the accepting edge the block runs the span division, the
// step settle, the axis divisions and the increment setup, then loads the
// output register with the first point and raises out_tvalid.
// Points leave one per cycle from the output register while out_tready keeps
// it free; a new segment is taken only once the controller is idle again.
// Reset: rst_n is synchronous and active low; it idles the controller and
// drops out_tvalid. Payload registers are not reset.
module vector_line_point_stroker import vlps_pkg::*; #(
  parameter int MAX_STEPS = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata fields from bit 0 up: x_start[15:0], y_start[31:16],
  // x_end[47:32], y_end[63:48], point_spacing[79:64].
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,
  // out_tdata fields from bit 0 up: point_x[15:0], point_y[31:16].
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // out_tlast carries last_point; out_tuser carries step_capped.
  output logic        out_tlast,
  output logic        out_tuser
);

  // The controller sequences one segment at a time: it takes an item only when
  // idle, runs the shared division lanes bit-serially, then walks the points.
  // A new segment may be accepted while the final point still waits in the
  // output register, since that register is only reloaded when it is free.
  vlps_cmd_t cmd;
  vlps_sts_t sts;

  vlps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // The datapath holds the segment, the two restoring-division lanes, the
  // incremental quotient and remainder accumulators and the output register.
  vlps_dp #(
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk       (clk),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule

// ===== rtl/vlps_checker.sv =====
// Port-level checks for the vector line point stroker, with its bind.
// Depends only on the ports of vector_line_point_stroker.
module vlps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // A stalled point holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output item changed");

  // Taking a segment closes the input until it has been stroked.
  a_one_segment: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // While a point other than the segment end is on offer, the input stays closed.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready in the middle of a segment");

  // The cap flag is the same on every point of a segment.
  a_cap_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> $stable(out_tuser))
    else $error("cap flag changed inside a segment");

endmodule

bind vector_line_point_stroker vlps_checker u_vlps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
